FILE: sv/iemp_pkg.sv
// ----------------------------------------------------------------------------
// iemp_pkg
// Shared types and constants for the inline emphasis markup parser: the
// request and result structures, the pending marker codes and the marker bytes.
// ----------------------------------------------------------------------------
package iemp_pkg;

    // Marker bytes.
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Result queue geometry.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Marker held while the next byte decides its meaning.
    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_ESC   = 3'd1,
        PEND_STAR1 = 3'd2,
        PEND_STAR2 = 3'd3,
        PEND_TILDE = 3'd4
    } t_pend;

    // One input request.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       label_last;
    } t_req;

    // One result item.
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_out;
        logic       is_bold;
        logic       is_italic;
        logic       is_code;
        logic       is_strike;
        logic       span_start;
        logic       label_end;
        logic       run_last;
    } t_res;

    // Builds a visible-character result with the given style flags.
    function automatic t_res mk_char(input logic [7:0] ch, input logic bold,
                                     input logic ital, input logic code,
                                     input logic strike, input logic sb);
        t_res r;
        r.has_char   = 1'b1;
        r.char_out   = ch;
        r.is_bold    = bold;
        r.is_italic  = ital;
        r.is_code    = code;
        r.is_strike  = strike;
        r.span_start = sb;
        r.label_end  = 1'b0;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

FILE: sv/inline_emphasis_markup_parser.sv
// ----------------------------------------------------------------------------
// inline_emphasis_markup_parser
// Streams a label one byte per request and returns each visible character
// tagged with bold, italic, code and strikethrough flags.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle. A byte that yields two results is offered as two
// results; the four-entry result queue absorbs them, and input stalls while three or
// more results wait, from output backpressure or from a run of two-result bytes.
// Reset (synchronous, active low) clears all style state, the pending marker and
// the result queue; the first character after reset starts a span.
module inline_emphasis_markup_parser
    import iemp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

    // Parser state.
    logic  r_bold, r_ital, r_code, r_strike, r_sb;
    t_pend r_pend;
    logic  n_bold, n_ital, n_code, n_strike, n_sb;
    t_pend n_pend;

    // Results of the current request.
    t_res       c_res [2];
    logic [1:0] c_num;

    // Result queue.
    t_res              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic in_acc, out_acc;

    assign o_in_stall  = (r_cnt > QCNT_W'(QDEPTH - 2));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_res   = r_q[r_rd];

    // Decode one byte against the current state.
    always_comb begin
        logic [7:0] b;
        logic       do_fresh, lit_tilde, emit_b;
        b         = i_in_req.char_byte;
        do_fresh  = 1'b0;
        lit_tilde = 1'b0;
        emit_b    = 1'b0;
        n_bold    = r_bold;
        n_ital    = r_ital;
        n_code    = r_code;
        n_strike  = r_strike;
        n_sb      = r_sb;
        n_pend    = r_pend;
        c_num     = 2'd0;
        c_res[0]  = '0;
        c_res[1]  = '0;

        if (r_code) begin
            // Inside a code span only a backtick is special.
            if (b == CH_BACKTICK) begin
                n_code = 1'b0;
                n_sb   = 1'b1;
            end else begin
                emit_b = 1'b1;
            end
        end else begin
            n_pend = PEND_NONE;
            unique case (r_pend)
                PEND_ESC: begin
                    emit_b = 1'b1;
                end
                PEND_STAR1: begin
                    if (b == CH_STAR) begin
                        n_pend = PEND_STAR2;
                    end else begin
                        n_ital   = ~n_ital;
                        n_sb     = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                PEND_STAR2: begin
                    n_sb = 1'b1;
                    if (b == CH_STAR) begin
                        n_bold = ~n_bold;
                        n_ital = ~n_ital;
                    end else begin
                        n_bold   = ~n_bold;
                        do_fresh = 1'b1;
                    end
                end
                PEND_TILDE: begin
                    if (b == CH_TILDE) begin
                        n_strike = ~n_strike;
                        n_sb     = 1'b1;
                    end else begin
                        lit_tilde = 1'b1;
                        do_fresh  = 1'b1;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase
        end

        // A lone tilde comes out ahead of the byte that follows it.
        if (lit_tilde) begin
            c_res[0] = mk_char(CH_TILDE, n_bold, n_ital, n_code, n_strike, n_sb);
            n_sb     = 1'b0;
            c_num    = 2'd1;
        end

        // Byte seen with nothing pending.
        if (do_fresh) begin
            case (b)
                CH_BACKSLASH: n_pend = PEND_ESC;
                CH_STAR:      n_pend = PEND_STAR1;
                CH_TILDE:     n_pend = PEND_TILDE;
                CH_BACKTICK: begin
                    n_code = 1'b1;
                    n_sb   = 1'b1;
                end
                default:      emit_b = 1'b1;
            endcase
        end

        if (emit_b && c_num != 2'd2) begin
            c_res[c_num[0]] = mk_char(b, n_bold, n_ital, n_code, n_strike, n_sb);
            n_sb            = 1'b0;
            c_num           = c_num + 2'd1;
        end

        // End of label: resolve the pending marker, then return to reset state.
        if (i_in_req.label_last) begin
            unique case (n_pend)
                PEND_ESC: begin
                    if (c_num != 2'd2) begin
                        c_res[c_num[0]] = mk_char(CH_BACKSLASH, n_bold, n_ital,
                                                  n_code, n_strike, n_sb);
                        c_num           = c_num + 2'd1;
                    end
                end
                PEND_TILDE: begin
                    if (c_num != 2'd2) begin
                        c_res[c_num[0]] = mk_char(CH_TILDE, n_bold, n_ital,
                                                  n_code, n_strike, n_sb);
                        c_num           = c_num + 2'd1;
                    end
                end
                default: begin
                end
            endcase
            if (c_num == 2'd0) begin
                c_res[0] = '0;
                c_num    = 2'd1;
            end
            c_res[c_num[1]].label_end = 1'b1;
            n_bold   = 1'b0;
            n_ital   = 1'b0;
            n_code   = 1'b0;
            n_strike = 1'b0;
            n_pend   = PEND_NONE;
            n_sb     = 1'b1;
        end

        if (c_num != 2'd0) begin
            c_res[c_num[1]].run_last = 1'b1;
        end
    end

    // State registers advance on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bold   <= 1'b0;
            r_ital   <= 1'b0;
            r_code   <= 1'b0;
            r_strike <= 1'b0;
            r_pend   <= PEND_NONE;
            r_sb     <= 1'b1;
        end else if (in_acc) begin
            r_bold   <= n_bold;
            r_ital   <= n_ital;
            r_code   <= n_code;
            r_strike <= n_strike;
            r_pend   <= n_pend;
            r_sb     <= n_sb;
        end
    end

    // Queue storage takes up to two results per request.
    always_ff @(posedge i_clk) begin
        if (in_acc && c_num != 2'd0) begin
            r_q[r_wr] <= c_res[0];
            if (c_num == 2'd2) begin
                r_q[r_wr + QPTR_W'(1)] <= c_res[1];
            end
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_acc) begin
                r_wr <= r_wr + QPTR_W'(c_num);
            end
            if (out_acc) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (in_acc ? QCNT_W'(c_num) : '0) - QCNT_W'(out_acc);
        end
    end

endmodule

FILE: sv/iemp_checker.sv
// ----------------------------------------------------------------------------
// iemp_checker
// Port-level checks for the inline emphasis markup parser, bound to the top.
// ----------------------------------------------------------------------------
module iemp_checker
    import iemp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_req,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_res o_out_res
);

    // A stalled result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    // The final result of a label is always the last one of its byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.label_end |-> o_out_res.run_last)
        else $error("label end without run last");

    // An end-only marker appears only at the end of a label and is blank.
    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.has_char |->
            o_out_res.label_end && o_out_res.char_out == 8'h00 &&
            !o_out_res.is_bold && !o_out_res.is_italic &&
            !o_out_res.is_code && !o_out_res.is_strike)
        else $error("malformed end-only result");

    // A backtick inside a code span closes it and is never shown.
    a_code_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.is_code |-> o_out_res.char_out != CH_BACKTICK)
        else $error("backtick shown inside code span");

    // Reset empties the result queue.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind inline_emphasis_markup_parser iemp_checker u_iemp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

FILE: tb/inline_emphasis_markup_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inline_emphasis_markup_parser_tb
// Self-checking testbench for the inline emphasis markup parser. A short table
// of labels covers the marker cases, then random labels built from marker and
// text tokens follow. An in-bench parser predicts every styled character. The
// results are compared field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module inline_emphasis_markup_parser_tb;
    import iemp_pkg::*;

    localparam int unsigned NUM_DIRECTED = 26;
    localparam int unsigned RANDOM_BYTES = 1124;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One row of the directed table; exp is used only when typed is set.
    typedef struct packed {
        t_req req;
        logic typed;
        t_res exp;
    } t_dir_row;

    localparam t_res NO_RES   = '0;
    localparam t_res END_ONLY = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        // Plain characters right after reset and at the byte extremes.
        '{'{8'h41, 1'b0}, 1'b1, '{1'b1, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{8'hFF, 1'b1}, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{8'h00, 1'b1}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
        // Labels that end with nothing visible give an end-only result.
        '{'{CH_STAR, 1'b1}, 1'b1, END_ONLY},
        '{'{CH_BACKTICK, 1'b1}, 1'b1, END_ONLY},
        // Italic, then a triple asterisk that closes italic and opens bold.
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{8'h78, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{8'h63, 1'b0}, 1'b0, NO_RES},
        // Strikethrough, then a lone tilde that comes out literally.
        '{'{CH_TILDE, 1'b0}, 1'b0, NO_RES},
        '{'{CH_TILDE, 1'b0}, 1'b0, NO_RES},
        '{'{8'h73, 1'b0}, 1'b0, NO_RES},
        '{'{CH_TILDE, 1'b0}, 1'b0, NO_RES},
        '{'{8'h74, 1'b0}, 1'b0, NO_RES},
        // Code span holding a backslash and an asterisk as plain text.
        '{'{CH_BACKTICK, 1'b0}, 1'b0, NO_RES},
        '{'{CH_BACKSLASH, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{CH_BACKTICK, 1'b0}, 1'b0, NO_RES},
        // Escaped asterisk, then trailing backslash and trailing tilde.
        '{'{CH_BACKSLASH, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{CH_BACKSLASH, 1'b1}, 1'b0, NO_RES},
        '{'{CH_TILDE, 1'b1}, 1'b0, NO_RES},
        // Double asterisk left open at the end of the label.
        '{'{CH_STAR, 1'b0}, 1'b0, NO_RES},
        '{'{CH_STAR, 1'b1}, 1'b0, NO_RES}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_req i_in_req    = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_res o_out_res;

    // Parser state kept by the testbench.
    logic  st_bold;
    logic  st_italic;
    logic  st_code;
    logic  st_strike;
    logic  st_span;
    t_pend st_pend;

    t_res        byte_results [$];
    t_res        styled_chars_due [$];
    logic [7:0]  label_buf [$];
    bit          idle_enable   = 1'b1;
    bit          hold_off_req  = 1'b0;
    int unsigned bytes_sent    = 0;
    int unsigned labels_sent   = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;

    inline_emphasis_markup_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // Clock generation, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser state as it stands after reset and after every final byte.
    function automatic void clear_parser();
        st_bold   = 1'b0;
        st_italic = 1'b0;
        st_code   = 1'b0;
        st_strike = 1'b0;
        st_span   = 1'b1;
        st_pend   = PEND_NONE;
    endfunction

    // Emits one visible character with the current style.
    function automatic void put_char(input logic [7:0] ch);
        t_res r;
        r            = '0;
        r.has_char   = 1'b1;
        r.char_out   = ch;
        r.is_bold    = st_bold;
        r.is_italic  = st_italic;
        r.is_code    = st_code;
        r.is_strike  = st_strike;
        r.span_start = st_span;
        st_span      = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // A byte seen with no marker pending: either starts a marker or is text.
    function automatic void take_plain(input logic [7:0] b);
        case (b)
            CH_BACKSLASH: st_pend = PEND_ESC;
            CH_STAR:      st_pend = PEND_STAR1;
            CH_TILDE:     st_pend = PEND_TILDE;
            CH_BACKTICK: begin
                st_code = 1'b1;
                st_span = 1'b1;
            end
            default:      put_char(b);
        endcase
    endfunction

    // Works out the styled characters that one input byte produces.
    function automatic void parse_markup_byte(input t_req rq);
        t_pend      held;
        logic [7:0] b;
        b = rq.char_byte;
        byte_results.delete();
        if (st_code) begin
            if (b == CH_BACKTICK) begin
                st_code = 1'b0;
                st_span = 1'b1;
            end else begin
                put_char(b);
            end
        end else begin
            held    = st_pend;
            st_pend = PEND_NONE;
            case (held)
                PEND_ESC: put_char(b);
                PEND_STAR1: begin
                    if (b == CH_STAR) begin
                        st_pend = PEND_STAR2;
                    end else begin
                        st_italic = ~st_italic;
                        st_span   = 1'b1;
                        take_plain(b);
                    end
                end
                PEND_STAR2: begin
                    st_span = 1'b1;
                    st_bold = ~st_bold;
                    if (b == CH_STAR) begin
                        st_italic = ~st_italic;
                    end else begin
                        take_plain(b);
                    end
                end
                PEND_TILDE: begin
                    if (b == CH_TILDE) begin
                        st_strike = ~st_strike;
                        st_span   = 1'b1;
                    end else begin
                        put_char(CH_TILDE);
                        take_plain(b);
                    end
                end
                default: take_plain(b);
            endcase
        end

        // End of label: flush a held marker and mark the final result.
        if (rq.label_last) begin
            case (st_pend)
                PEND_ESC:   put_char(CH_BACKSLASH);
                PEND_STAR1: st_italic = ~st_italic;
                PEND_STAR2: st_bold = ~st_bold;
                PEND_TILDE: put_char(CH_TILDE);
                default: ;
            endcase
            if (byte_results.size() == 0) begin
                byte_results = {byte_results, NO_RES};
            end
            byte_results[byte_results.size() - 1].label_end = 1'b1;
            clear_parser();
        end

        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].run_last = 1'b1;
        end
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input t_req rq);
        while (idle_enable && ($urandom_range(0, 99) < 14)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        if (rq.label_last) begin
            labels_sent++;
        end
    endtask

    // Builds a random label from marker and text tokens; long ones are rare.
    function automatic void build_label();
        int unsigned ntok;
        int unsigned k;
        int unsigned m;
        logic [7:0]  b;
        label_buf.delete();
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (k = 0; k < ntok; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    for (m = $urandom_range(1, 3); m > 0; m--) begin
                        label_buf = {label_buf, CH_STAR};
                    end
                end
                1: begin
                    label_buf = {label_buf, CH_TILDE, CH_TILDE};
                end
                2: label_buf = {label_buf, CH_TILDE};
                3: label_buf = {label_buf, CH_BACKTICK};
                4: begin
                    b         = 8'($urandom_range(0, 255));
                    label_buf = {label_buf, CH_BACKSLASH, b};
                end
                5: label_buf = {label_buf, CH_BACKSLASH};
                default: begin
                    for (m = $urandom_range(1, 3); m > 0; m--) begin
                        b         = 8'($urandom_range(0, 255));
                        label_buf = {label_buf, b};
                    end
                end
            endcase
        end
    endfunction

    // Reports one field that differs from its expectation.
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_out_stall <= idle_enable && ($urandom_range(0, 99) < 14);
                @(posedge i_clk);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (styled_chars_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %p",
                         $time, o_out_res);
                mismatches++;
            end else begin
                want = styled_chars_due.pop_front();
                check_field("has_char", 8'(want.has_char), 8'(o_out_res.has_char));
                check_field("char_out", want.char_out, o_out_res.char_out);
                check_field("is_bold", 8'(want.is_bold), 8'(o_out_res.is_bold));
                check_field("is_italic", 8'(want.is_italic), 8'(o_out_res.is_italic));
                check_field("is_code", 8'(want.is_code), 8'(o_out_res.is_code));
                check_field("is_strike", 8'(want.is_strike), 8'(o_out_res.is_strike));
                check_field("span_start", 8'(want.span_start),
                            8'(o_out_res.span_start));
                check_field("label_end", 8'(want.label_end), 8'(o_out_res.label_end));
                check_field("run_last", 8'(want.run_last), 8'(o_out_res.run_last));
                chars_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results still due",
                     $time, styled_chars_due.size());
            $display("inline_emphasis_markup_parser_tb failed");
            $finish;
        end
    end

    // Stimulus: directed table, then random labels.
    initial begin : stimulus
        int unsigned k;
        t_req        rq;
        bit          held_once;
        held_once = 1'b0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows are checked against their own values.
        for (k = 0; k < NUM_DIRECTED; k++) begin
            send_request(DIRECTED[k].req);
            parse_markup_byte(DIRECTED[k].req);
            if (DIRECTED[k].typed) begin
                styled_chars_due = {styled_chars_due, DIRECTED[k].exp};
            end else begin
                styled_chars_due = {styled_chars_due, byte_results};
            end
        end

        // Random labels; one stretch runs without idling on either side.
        while (bytes_sent < NUM_DIRECTED + RANDOM_BYTES) begin
            idle_enable = !(bytes_sent >= 400 && bytes_sent < 650);
            if (!held_once && bytes_sent >= 800) begin
                hold_off_req = 1'b1;
                held_once    = 1'b1;
            end
            build_label();
            foreach (label_buf[j]) begin
                rq.char_byte  = label_buf[j];
                rq.label_last = (j == label_buf.size() - 1);
                send_request(rq);
                parse_markup_byte(rq);
                styled_chars_due = {styled_chars_due, byte_results};
            end
        end
        i_in_valid <= 1'b0;

        while (styled_chars_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d labels and checked %0d results,",
                 bytes_sent, labels_sent, chars_checked);
        $display("with random idling, a no-idle stretch and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && styled_chars_due.size() == 0) begin
            $display("inline_emphasis_markup_parser_tb passed");
        end else begin
            $display("inline_emphasis_markup_parser_tb failed");
        end
        $finish;
    end

endmodule
